// ===== hw/rtl/bcgr_pkg.sv =====
// Shared types and constants for the bilinear cell grid resampler.
`timescale 1ns / 1ps
package bcgr_pkg;

    localparam int NUM_CFG_REGS = 6;

    typedef enum logic [2:0] {
        CFG_OLD_WIDTH      = 3'd0,
        CFG_OLD_HEIGHT     = 3'd1,
        CFG_NEW_WIDTH      = 3'd2,
        CFG_NEW_HEIGHT     = 3'd3,
        CFG_AIR_CODE       = 3'd4,
        CFG_FILL_THRESHOLD = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_WEIGHT,
        ST_READ,
        ST_ACCUM,
        ST_FIX,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/bcgr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bcgr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/bilinear_cell_grid_resampler_top.sv =====
// Top level of the bilinear cell grid resampler.
`timescale 1ns / 1ps
// Channel   | Direction | Handshake         | Payload
// s_        | in        | s_valid/s_ready   | op, cell x/y, material, fill, com, vel
// m_        | out       | m_valid/m_ready   | material, fill, com, vel, x, y
// cfg_      | in        | cfg_we            | cfg_index, cfg_data (16 bits)
//
// A query keeps the block busy before m_valid rises: two passes of one shared restoring
// divider (load, then 41 quotient bits, one per cycle), corner weights, registered RAM
// reads, 20 multiply-accumulate steps on one shared 17x34 signed multiplier, air
// fix-up and raising of the result.
// The result register holds until m_ready; s_ready stays low until the cycle after
// the result transaction.
// Reset (aresetn, synchronous) restores the configuration defaults and the
// sequencer; the source store is not cleared.
module bilinear_cell_grid_resampler_top
    import bcgr_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 64,
    parameter int MAX_SRC_HEIGHT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [11:0]        s_cell_x,
    input  logic [11:0]        s_cell_y,
    input  logic [3:0]         s_material,
    input  logic [15:0]        s_fill,
    input  logic signed [15:0] s_com_x,
    input  logic signed [15:0] s_com_y,
    input  logic signed [15:0] s_vel_x,
    input  logic signed [15:0] s_vel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_out_material,
    output logic [15:0]        m_out_fill,
    output logic signed [15:0] m_out_com_x,
    output logic signed [15:0] m_out_com_y,
    output logic signed [15:0] m_out_vel_x,
    output logic signed [15:0] m_out_vel_y,
    output logic [11:0]        m_out_x,
    output logic [11:0]        m_out_y
);
    localparam int XW    = (MAX_SRC_WIDTH  > 1) ? $clog2(MAX_SRC_WIDTH)  : 1;
    localparam int YW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int RECW  = 4 + 16 + 64;
    // numerator width: (2d+1)*old < 2^13 * 2^11 ; quotient + 16 fraction bits
    localparam int NW    = 25;
    localparam int QW    = NW + 16;
    localparam int DW    = 14;
    localparam int DCW   = $clog2(QW + 1);

    // ---------------- configuration ----------------
    logic [6:0]  old_w_reg, old_h_reg;
    logic [12:0] new_w_reg, new_h_reg;
    logic [3:0]  air_reg;
    logic [15:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_w_reg <= 7'd64;  old_h_reg <= 7'd64;
            new_w_reg <= 13'd64; new_h_reg <= 13'd64;
            air_reg   <= 4'd0;   thr_reg   <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_OLD_WIDTH:      old_w_reg <= cfg_data[6:0];
                CFG_OLD_HEIGHT:     old_h_reg <= cfg_data[6:0];
                CFG_NEW_WIDTH:      new_w_reg <= cfg_data[12:0];
                CFG_NEW_HEIGHT:     new_h_reg <= cfg_data[12:0];
                CFG_AIR_CODE:       air_reg   <= cfg_data[3:0];
                CFG_FILL_THRESHOLD: thr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated sizes
    logic [10:0] ow, oh;
    logic [12:0] nw, nh;
    always_comb begin
        ow = (old_w_reg == 7'd0) ? 11'd1 :
             ({4'd0, old_w_reg} > 11'(MAX_SRC_WIDTH)) ? 11'(MAX_SRC_WIDTH) : {4'd0, old_w_reg};
        oh = (old_h_reg == 7'd0) ? 11'd1 :
             ({4'd0, old_h_reg} > 11'(MAX_SRC_HEIGHT)) ? 11'(MAX_SRC_HEIGHT) : {4'd0, old_h_reg};
        nw = (new_w_reg == 13'd0) ? 13'd1 : new_w_reg;
        nh = (new_h_reg == 13'd0) ? 13'd1 : new_h_reg;
    end

    // ---------------- sequencer ----------------
    state_t state_reg, state_next;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic [4:0]     step_reg, step_next;
    logic [11:0]    qx_reg, qy_reg;

    // divider
    logic [QW-1:0]  quo_reg;
    logic [DW:0]    rem_reg;
    logic [NW-1:0]  num_reg;
    logic           neg_reg;
    logic [DW-1:0]  den;
    logic [DW:0]    rem_sh, rem_sub;
    logic           rem_ge;

    // results of axis mapping
    logic [16:0] fx_reg, fy_reg;     // fraction, up to 65535
    logic [10:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [32:0] w_reg [4];

    // RAM
    logic [AW-1:0]   raddr;
    logic [RECW-1:0] rdata;
    logic [RECW-1:0] cor_reg [4];
    logic            wr_en;

    // MAC
    logic signed [49:0] acc_reg, acc_next;
    logic signed [16:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [49:0] prod;
    logic signed [17:0] res_reg [5];

    // output
    logic        mv_reg;
    logic [3:0]  mat_reg;

    assign den = (state_reg == ST_DIV_X) ? {nw, 1'b0} : {nh, 1'b0};

    assign wr_en = s_valid && s_ready && (s_op == OP_WRITE) &&
                   (s_cell_x < 12'(MAX_SRC_WIDTH)) && (s_cell_y < 12'(MAX_SRC_HEIGHT));

    bcgr_ram #(.WIDTH(RECW), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr ({s_cell_y[YW-1:0], s_cell_x[XW-1:0]}),
        .wdata ({s_material, s_fill, s_com_y, s_com_x, s_vel_y, s_vel_x}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready && s_op == OP_QUERY) begin
                    state_next = ST_DIV_X;
                    cnt_next   = '0;
                end
            end
            ST_DIV_X: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(QW)) begin
                    state_next = ST_DIV_Y;
                    cnt_next   = '0;
                end
            end
            ST_DIV_Y: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(QW)) begin
                    state_next = ST_WEIGHT;
                    cnt_next   = '0;
                end
            end
            ST_WEIGHT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(3)) begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                end
            end
            ST_READ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(4)) begin
                    state_next = ST_ACCUM;
                    step_next  = '0;
                end
            end
            ST_ACCUM: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd19) state_next = ST_FIX;
            end
            ST_FIX:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // read address per corner
    logic [10:0] rx, ry;
    always_comb begin
        rx = cnt_reg[0] ? x1_reg : x0_reg;
        ry = cnt_reg[1] ? y1_reg : y0_reg;
        raddr = {ry[YW-1:0], rx[XW-1:0]};
    end

    // divider step: iteration 0 loads, then one quotient bit per cycle
    assign rem_sh  = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign rem_ge  = rem_sh >= {1'b0, den};
    assign rem_sub = rem_ge ? rem_sh - {1'b0, den} : rem_sh;

    // setup of each axis numerator
    logic [11:0] dsel;
    logic [10:0] osel;
    logic [12:0] nsel;
    logic [NW-1:0] prodn;
    logic signed [NW+1:0] numv;
    always_comb begin
        dsel  = (state_reg == ST_DIV_X) ? qx_reg : qy_reg;
        osel  = (state_reg == ST_DIV_X) ? ow : oh;
        nsel  = (state_reg == ST_DIV_X) ? nw : nh;
        prodn = NW'({dsel, 1'b1} * osel);
        numv  = $signed({2'b00, prodn}) - $signed({{(NW-13){1'b0}}, 2'b00, nsel});
    end

    // corner clamp for a base b in -1..
    function automatic logic [10:0] clampi(input logic signed [26:0] v, input logic [10:0] n);
        if (v < 0) return 11'd0;
        if (v > $signed({16'd0, n}) - 1) return n - 11'd1;
        return v[10:0];
    endfunction

    // MAC operand selection: step = field*4 + corner
    logic [2:0]  fld;
    logic [1:0]  crn;
    logic [RECW-1:0] cr;
    always_comb begin
        fld = 3'(step_reg >> 2);
        crn = step_reg[1:0];
        cr  = cor_reg[crn];
        case (fld)
            3'd0:    mul_a = {1'b0, cr[79:64]};
            3'd1:    mul_a = {cr[47], cr[47:32]};
            3'd2:    mul_a = {cr[63], cr[63:48]};
            3'd3:    mul_a = {cr[15], cr[15:0]};
            default: mul_a = {cr[31], cr[31:16]};
        endcase
        mul_b    = $signed({1'b0, w_reg[crn]});
        prod     = mul_a * mul_b;
        acc_next = (crn == 2'd0) ? prod : acc_reg + prod;
    end

    // air fix-up
    logic [3:0]  mat_fix;
    logic [15:0] fill_fix;
    logic        near_hi_x, near_hi_y;
    logic [1:0]  near_c;
    logic [3:0]  best_m;
    logic [15:0] best_f;
    logic        found;
    logic signed [17:0] fill_i;
    always_comb begin
        near_hi_x = fx_reg[15];
        near_hi_y = fy_reg[15];
        near_c    = {near_hi_y, near_hi_x};
        mat_fix   = cor_reg[near_c][83:80];
        fill_i    = res_reg[0];
        best_m    = mat_fix;
        best_f    = 16'd0;
        found     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (cor_reg[i][83:80] != air_reg && cor_reg[i][79:64] > best_f) begin
                best_f = cor_reg[i][79:64];
                best_m = cor_reg[i][83:80];
                found  = 1'b1;
            end
        end
        if (mat_fix == air_reg && fill_i > $signed({2'b00, thr_reg})) begin
            mat_fix = best_m;
            if (!found) fill_i = '0;
        end
        if (fill_i < 0) fill_fix = 16'd0;
        else if (fill_i > 18'sd32768) fill_fix = 16'd32768;
        else fill_fix = fill_i[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            if (state_reg == ST_OUT) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            qx_reg <= s_cell_x;
            qy_reg <= s_cell_y;
        end
        case (state_reg)
            ST_DIV_X, ST_DIV_Y: begin
                if (cnt_reg == '0) begin
                    neg_reg <= numv < 0;
                    num_reg <= (numv < 0) ? NW'(numv + $signed({13'd0, nsel, 1'b0}))
                                          : numv[NW-1:0];
                    rem_reg <= '0;
                    quo_reg <= '0;
                end else if (cnt_reg <= DCW'(QW)) begin
                    rem_reg <= rem_sub;
                    // fraction bits: feed zeros after numerator bits
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    quo_reg <= {quo_reg[QW-2:0], rem_ge};
                end
                if (cnt_reg == DCW'(QW)) begin
                    if (state_reg == ST_DIV_X) begin
                        fx_reg <= {1'b0, quo_reg[14:0], rem_ge};
                        x0_reg <= clampi(neg_reg ? -27'sd1 : $signed({2'b0, quo_reg[QW-2:15]}), ow);
                        x1_reg <= clampi(neg_reg ? 27'sd0
                                                 : $signed({2'b0, quo_reg[QW-2:15]}) + 27'sd1, ow);
                    end else begin
                        fy_reg <= {1'b0, quo_reg[14:0], rem_ge};
                        y0_reg <= clampi(neg_reg ? -27'sd1 : $signed({2'b0, quo_reg[QW-2:15]}), oh);
                        y1_reg <= clampi(neg_reg ? 27'sd0
                                                 : $signed({2'b0, quo_reg[QW-2:15]}) + 27'sd1, oh);
                    end
                end
            end
            ST_WEIGHT: begin
                w_reg[cnt_reg[1:0]] <=
                    (cnt_reg[0] ? fx_reg : 17'd65536 - fx_reg) *
                    (cnt_reg[1] ? fy_reg : 17'd65536 - fy_reg);
            end
            ST_READ: begin
                if (cnt_reg != '0) cor_reg[2'(cnt_reg - 1'b1)] <= rdata;
            end
            ST_ACCUM: begin
                acc_reg <= acc_next;
                if (crn == 2'd3) res_reg[fld] <= 18'(acc_next >>> 32);
            end
            ST_FIX: begin
                mat_reg        <= mat_fix;
                m_out_fill     <= fill_fix;
                m_out_com_x    <= res_reg[1][15:0];
                m_out_com_y    <= res_reg[2][15:0];
                m_out_vel_x    <= res_reg[3][15:0];
                m_out_vel_y    <= res_reg[4][15:0];
                m_out_x        <= qx_reg;
                m_out_y        <= qy_reg;
            end
            default: ;
        endcase
    end

    assign m_valid        = mv_reg;
    assign m_out_material = mat_reg;
endmodule

// ===== hw/rtl/bcgr_checker.sv =====
// Port-level checker for the resampler, bound to the top level.
`timescale 1ns / 1ps
module bcgr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_op,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_out_x,
    input logic [15:0] m_out_fill
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x)) else $error("result dropped");
    a_fill_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_fill <= 16'd32768) else $error("fill out of range");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> !s_ready) else $error("ready during query");
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> !m_valid) else $error("result too early");
endmodule

bind bilinear_cell_grid_resampler_top bcgr_checker u_bcgr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
    .m_valid(m_valid), .m_ready(m_ready), .m_out_x(m_out_x), .m_out_fill(m_out_fill)
);

// ===== tb/tb.sv =====
// Testbench for the bilinear cell grid resampler: random cell writes and queries against a predictor.
`timescale 1ns / 1ps

module tb;
    import bcgr_pkg::*;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int GRID_CELLS = GRID_W * GRID_H;
    localparam int RAND_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 120;

    // One transaction on the input channel.
    typedef struct {
        op_t         op;
        logic [11:0] x;
        logic [11:0] y;
        logic [3:0]  mat;
        logic [15:0] fill;
        logic [15:0] com_x;
        logic [15:0] com_y;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
    } cell_item_t;

    // One transaction on the result channel.
    typedef struct {
        logic [3:0]  mat;
        logic [15:0] fill;
        logic [15:0] com_x;
        logic [15:0] com_y;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [11:0] x;
        logic [11:0] y;
    } cell_result_t;

    // Mirror of the resampler: its own source grid, its registers and the
    // queue of destination cells still to come out.
    class resample_scoreboard;
        logic [3:0]   grid_mat[GRID_CELLS];
        logic [15:0]  grid_fill[GRID_CELLS];
        logic [15:0]  grid_cx[GRID_CELLS];
        logic [15:0]  grid_cy[GRID_CELLS];
        logic [15:0]  grid_vx[GRID_CELLS];
        logic [15:0]  grid_vy[GRID_CELLS];
        bit           written[GRID_CELLS];
        int unsigned  old_w, old_h, new_w, new_h, air, thresh;
        cell_result_t pending_cells[$];
        int           errors;

        function new();
            foreach (written[i]) written[i] = 0;
            errors = 0;
            old_w = 64; old_h = 64; new_w = 64; new_h = 64; air = 0; thresh = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            case (idx)
                CFG_OLD_WIDTH:      old_w  = val[6:0];
                CFG_OLD_HEIGHT:     old_h  = val[6:0];
                CFG_NEW_WIDTH:      new_w  = val[12:0];
                CFG_NEW_HEIGHT:     new_h  = val[12:0];
                CFG_AIR_CODE:       air    = val[3:0];
                CFG_FILL_THRESHOLD: thresh = val;
                default: ;
            endcase
        endfunction

        // Floor and 16-bit fraction of (d + 0.5) * old / new - 0.5.
        function void split_pos(longint d, longint o, longint n,
                                output longint base, output longint frac);
            longint num, den, r;
            num = (2 * d + 1) * o - n;
            den = 2 * n;
            if (num < 0) begin
                base = -1;
                r = num + den;
            end else begin
                base = num / den;
                r = num % den;
            end
            frac = (r << 16) / den;
        endfunction

        function int unsigned clip(longint v, int unsigned n);
            if (v < 0) return 0;
            if (v > longint'(n) - 1) return n - 1;
            return 32'(v);
        endfunction

        // Corner addresses 00, 10, 01, 11 plus the fractions of a query.
        function void corners(logic [11:0] x, logic [11:0] y, output int a[4],
                              output longint fx, output longint fy);
            int unsigned ow, oh, nw, nh, x0, x1, y0, y1;
            longint bx, by;
            ow = old_w < 1 ? 1 : (old_w > GRID_W ? GRID_W : old_w);
            oh = old_h < 1 ? 1 : (old_h > GRID_H ? GRID_H : old_h);
            nw = new_w < 1 ? 1 : new_w;
            nh = new_h < 1 ? 1 : new_h;
            split_pos(x, ow, nw, bx, fx);
            split_pos(y, oh, nh, by, fy);
            x0 = clip(bx, ow); x1 = clip(bx + 1, ow);
            y0 = clip(by, oh); y1 = clip(by + 1, oh);
            a[0] = y0 * GRID_W + x0; a[1] = y0 * GRID_W + x1;
            a[2] = y1 * GRID_W + x0; a[3] = y1 * GRID_W + x1;
        endfunction

        // Weighted sum over 2^32, floored.
        function longint mix(longint v[4], longint w[4]);
            longint s;
            s = 0;
            for (int i = 0; i < 4; i++) s += v[i] * w[i];
            return s >>> 32;
        endfunction

        function void note_item(cell_item_t it);
            int           a[4];
            longint       fx, fy, fillv, best;
            longint       w[4], v[4];
            logic [3:0]   m;
            bit           found;
            cell_result_t r;
            int           addr;
            if (it.op == OP_WRITE) begin
                if (it.x < GRID_W && it.y < GRID_H) begin
                    addr = it.y * GRID_W + it.x;
                    grid_mat[addr] = it.mat;  grid_fill[addr] = it.fill;
                    grid_cx[addr] = it.com_x; grid_cy[addr] = it.com_y;
                    grid_vx[addr] = it.vel_x; grid_vy[addr] = it.vel_y;
                    written[addr] = 1;
                end
                return;
            end
            corners(it.x, it.y, a, fx, fy);
            w[0] = (65536 - fx) * (65536 - fy); w[1] = fx * (65536 - fy);
            w[2] = (65536 - fx) * fy;           w[3] = fx * fy;
            m = grid_mat[a[(fy >= 32768 ? 2 : 0) + (fx >= 32768 ? 1 : 0)]];
            foreach (v[i]) v[i] = grid_fill[a[i]];
            fillv = mix(v, w);
            // Air at the nearest corner but real fill: borrow the fullest solid corner.
            if (m == air && fillv > thresh) begin
                best = 0;
                found = 0;
                for (int i = 0; i < 4; i++) begin
                    if (grid_mat[a[i]] != air && grid_fill[a[i]] > best) begin
                        best = grid_fill[a[i]];
                        m = grid_mat[a[i]];
                        found = 1;
                    end
                end
                if (!found) fillv = 0;
            end
            if (fillv < 0) fillv = 0;
            if (fillv > 32768) fillv = 32768;
            r.mat = m;
            r.fill = fillv[15:0];
            foreach (v[i]) v[i] = longint'($signed(grid_cx[a[i]]));
            r.com_x = 16'(mix(v, w));
            foreach (v[i]) v[i] = longint'($signed(grid_cy[a[i]]));
            r.com_y = 16'(mix(v, w));
            foreach (v[i]) v[i] = longint'($signed(grid_vx[a[i]]));
            r.vel_x = 16'(mix(v, w));
            foreach (v[i]) v[i] = longint'($signed(grid_vy[a[i]]));
            r.vel_y = 16'(mix(v, w));
            r.x = it.x;
            r.y = it.y;
            pending_cells = {pending_cells, r};
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(cell_result_t got);
            cell_result_t e;
            if (pending_cells.size() == 0) begin
                report($sformatf("unexpected result for cell %0d,%0d", got.x, got.y));
                return;
            end
            e = pending_cells.pop_front();
            if (got.mat !== e.mat)
                report($sformatf("material %0d exp %0d at %0d,%0d", got.mat, e.mat, e.x, e.y));
            if (got.fill !== e.fill)
                report($sformatf("fill %h exp %h at %0d,%0d", got.fill, e.fill, e.x, e.y));
            if (got.com_x !== e.com_x)
                report($sformatf("com_x %h exp %h at %0d,%0d", got.com_x, e.com_x, e.x, e.y));
            if (got.com_y !== e.com_y)
                report($sformatf("com_y %h exp %h at %0d,%0d", got.com_y, e.com_y, e.x, e.y));
            if (got.vel_x !== e.vel_x)
                report($sformatf("vel_x %h exp %h at %0d,%0d", got.vel_x, e.vel_x, e.x, e.y));
            if (got.vel_y !== e.vel_y)
                report($sformatf("vel_y %h exp %h at %0d,%0d", got.vel_y, e.vel_y, e.x, e.y));
            if (got.x !== e.x || got.y !== e.y)
                report($sformatf("cell %0d,%0d exp %0d,%0d", got.x, got.y, e.x, e.y));
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic [11:0]        s_cell_x, s_cell_y;
    logic [3:0]         s_material;
    logic [15:0]        s_fill;
    logic signed [15:0] s_com_x, s_com_y, s_vel_x, s_vel_y;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_out_material;
    logic [15:0]        m_out_fill;
    logic signed [15:0] m_out_com_x, m_out_com_y, m_out_vel_x, m_out_vel_y;
    logic [11:0]        m_out_x, m_out_y;

    resample_scoreboard sb;
    bit                 idling_on;   // cleared for the no-idle stretch
    int                 items_sent;  // input transactions accepted so far

    bilinear_cell_grid_resampler_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_cell_x(s_cell_x), .s_cell_y(s_cell_y), .s_material(s_material),
        .s_fill(s_fill), .s_com_x(s_com_x), .s_com_y(s_com_y),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_material(m_out_material), .m_out_fill(m_out_fill),
        .m_out_com_x(m_out_com_x), .m_out_com_y(m_out_com_y),
        .m_out_vel_x(m_out_vel_x), .m_out_vel_y(m_out_vel_y),
        .m_out_x(m_out_x), .m_out_y(m_out_y)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

    // Result side: ready toggles at the falling edge, transactions are
    // checked at the rising edge with the values held before it.
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !(idling_on && $urandom_range(99) < 27);
    end

    always @(posedge aclk) begin
        cell_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.mat = m_out_material; got.fill = m_out_fill;
            got.com_x = m_out_com_x;  got.com_y = m_out_com_y;
            got.vel_x = m_out_vel_x;  got.vel_y = m_out_vel_y;
            got.x = m_out_x;          got.y = m_out_y;
            sb.check_result(got);
        end
    end

    // Push one transaction; valid stays up from one item to the next unless
    // an idle gap is drawn.
    task send_item(cell_item_t it);
        if (idling_on && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= it.op;
        s_cell_x   <= it.x;     s_cell_y <= it.y;
        s_material <= it.mat;   s_fill   <= it.fill;
        s_com_x    <= it.com_x; s_com_y  <= it.com_y;
        s_vel_x    <= it.vel_x; s_vel_y  <= it.vel_y;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
        @(negedge aclk);
    endtask

    function cell_item_t rand_cell(int unsigned x, int unsigned y);
        cell_item_t it;
        it.op = OP_WRITE;
        it.x = 12'(x); it.y = 12'(y);
        // Air shows up often so the material fix gets exercised.
        it.mat = ($urandom_range(99) < 35) ? 4'(sb.air) : 4'($urandom);
        case ($urandom_range(3))
            0: it.fill = 16'($urandom);
            1: it.fill = 16'd32768;
            default: it.fill = 16'($urandom_range(32768));
        endcase
        it.com_x = 16'($urandom); it.com_y = 16'($urandom);
        it.vel_x = 16'($urandom); it.vel_y = 16'($urandom);
        return it;
    endfunction

    // A query whose corners are not all stored yet gets them written first.
    task send_query(int unsigned x, int unsigned y);
        int         a[4];
        longint     fx, fy;
        cell_item_t q;
        sb.corners(12'(x), 12'(y), a, fx, fy);
        foreach (a[i])
            if (!sb.written[a[i]]) send_item(rand_cell(a[i] % GRID_W, a[i] / GRID_W));
        q = rand_cell(0, 0);
        q.op = OP_QUERY;
        q.x = 12'(x); q.y = 12'(y);
        send_item(q);
    endtask

    // Registers change only with the block idle: all results in, then a
    // pause covering a query still in flight.
    task set_regs(int unsigned ow, int unsigned oh, int unsigned nw, int unsigned nh,
                  int unsigned air_c, int unsigned thr);
        logic [15:0] vals[6];
        vals = '{16'(ow), 16'(oh), 16'(nw), 16'(nh), 16'(air_c), 16'(thr)};
        s_valid <= 1'b0;
        while (sb.pending_cells.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        for (int i = 0; i < NUM_CFG_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(negedge aclk);
            sb.set_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Runs until n transactions, corner writes included, have gone in.
    task random_items(int n);
        int unsigned nw, nh;
        int          start, k;
        start = items_sent;
        while (items_sent - start < n) begin
            k = items_sent - start;
            // A long run in the middle with both sides always ready.
            idling_on = !(k >= n / 3 && k < n / 2);
            nw = sb.new_w < 1 ? 1 : (sb.new_w > 4096 ? 4096 : sb.new_w);
            nh = sb.new_h < 1 ? 1 : (sb.new_h > 4096 ? 4096 : sb.new_h);
            case ($urandom_range(9))
                0, 1, 2:
                    send_item(rand_cell($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1)));
                3: begin
                    // Writes that may land outside the store and get dropped.
                    send_item(rand_cell($urandom_range(4095), $urandom_range(4095)));
                end
                4:
                    send_query($urandom_range(4095), $urandom_range(4095));
                default:
                    send_query($urandom_range(nw - 1), $urandom_range(nh - 1));
            endcase
        end
    endtask

    initial begin
        cell_item_t it;
        sb = new();
        idling_on = 1;
        items_sent = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_op = OP_WRITE;
        s_cell_x = '0; s_cell_y = '0; s_material = '0; s_fill = '0;
        s_com_x = '0; s_com_y = '0; s_vel_x = '0; s_vel_y = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: defaults, field extremes, grid corners, dropped writes.
        it = rand_cell(0, 0);
        it.mat = 4'hF; it.fill = 16'hFFFF;
        it.com_x = 16'h7FFF; it.com_y = 16'h8000; it.vel_x = 16'h8000; it.vel_y = 16'h7FFF;
        send_item(it);
        it = rand_cell(63, 63);
        it.mat = 4'h0; it.fill = 16'h0000;
        it.com_x = 16'h8000; it.com_y = 16'h7FFF; it.vel_x = 16'hFFFF; it.vel_y = 16'h0000;
        send_item(it);
        send_item(rand_cell(4095, 4095));
        send_item(rand_cell(64, 0));
        send_item(rand_cell(0, 64));
        send_query(0, 0);
        send_query(63, 63);
        send_query(32, 17);
        send_query(4095, 4095);
        send_query(64, 0);

        // Shrink to one source cell, then a one-cell destination.
        set_regs(1, 1, 1, 1, 15, 32768);
        send_query(0, 0);
        send_query(4095, 0);
        // Zero sizes saturate / count as one; old sizes above the store clamp.
        set_regs(0, 127, 0, 8191, 0, 0);
        send_query(0, 0);
        send_query(0, 8000 % 4096);
        send_query(4095, 4095);
        // Large upscale with fix-up threshold at full.
        set_regs(64, 64, 4096, 4096, 3, 32768);
        send_query(0, 0);
        send_query(4095, 4095);
        send_query(2047, 1);

        random_items(RAND_ITEMS / 4);
        set_regs(8, 5, 13, 3, 0, 16384);
        random_items(RAND_ITEMS / 4);
        set_regs(64, 64, 64, 64, 0, 0);
        random_items(RAND_ITEMS / 4);
        set_regs($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 200),
                 $urandom_range(1, 200), $urandom_range(15), $urandom_range(32768));
        random_items(RAND_ITEMS / 4);

        s_valid <= 1'b0;
        while (sb.pending_cells.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
